FILE: src/fbr_pkg.sv
// Shared constants and types for the framed base-128 receiver.
`timescale 1ns / 1ps

package fbr_pkg;

   // symbol counter width and the largest count it can hold
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // field widths
   localparam int BYTE_W = 8;
   localparam int SYM_W = 7;
   localparam int HELD_W = 3;
   localparam int KIND_W = 2;
   localparam int LEN_W = 16;
   localparam int CFG_W = 16;

   // width for comparing the counter against the configured limit
   localparam int LIM_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
   // width for count * 7, padded so it always covers the length field
   localparam int PROD_W = COUNT_BITS + 3 + LEN_W;

   // CSR interface
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic [0:0] REG_MAX_SYMBOLS = 1'b0;
   localparam logic [CFG_W-1:0] MAX_SYMBOLS_RESET = 16'hFFFF;

   // line markers
   localparam logic [BYTE_W-1:0] MARK_START = 8'hD4;
   localparam logic [BYTE_W-1:0] MARK_END = 8'h81;

   // result kinds
   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_DATA = 2'd0;
   localparam kind_type KIND_DONE = 2'd1;
   localparam kind_type KIND_INVALID = 2'd2;
   localparam kind_type KIND_OVERFLOW = 2'd3;

   // per-frame decode state
   typedef struct packed {
      logic in_frame;
      logic [COUNT_BITS-1:0] symbol_count;
      logic [SYM_W-1:0] bit_store;
      logic [HELD_W-1:0] bits_held;
   } frame_state_type;

endpackage

FILE: src/framed_base128_receiver_unit.sv
// Framed base-128 receiver: marker detection, 7-to-8 bit repack, result register.
`timescale 1ns / 1ps

// Usage:
//   req_* carries one received line byte per item. 0xD4 opens a frame, 0x81
//   closes it, other bytes with bit 7 set abort it. Payload bytes (bit 7
//   clear) give 7 bits each, packed MSB first into 8-bit data results.
//   rsp_* carries at most one result item per input item: a data byte, a
//   frame done with its length (symbols * 7 / 8), an invalid frame or an
//   overflow. Downstream drops the data of a frame that ends in error.
//   csr_* is an APB-style port; max_symbols lies at byte address 0.
// Timing:
//   One input item per cycle. A result appears in the output register in the
//   cycle after its item is accepted; the decode is a single level of
//   compare and repack logic between the state/result registers.
//   While the output register holds an item and rsp_stall is high,
//   req_stall is high and no input is taken; otherwise input flows freely.
// Reset:
//   Synchronous, active high. Clears the frame state and the output valid,
//   and sets max_symbols to 65535.

module framed_base128_receiver_unit (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [fbr_pkg::BYTE_W-1:0]  req_in_byte,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fbr_pkg::KIND_W-1:0]  rsp_kind,
   output logic [fbr_pkg::BYTE_W-1:0]  rsp_data_byte,
   output logic [fbr_pkg::LEN_W-1:0]   rsp_frame_length,
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [fbr_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [fbr_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [fbr_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   fbr_pkg::frame_state_type state_ff, state_in;
   logic [fbr_pkg::CFG_W-1:0] max_symbols_ff, max_symbols_in;

   logic rsp_valid_ff, rsp_valid_in;
   fbr_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [fbr_pkg::BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [fbr_pkg::LEN_W-1:0] rsp_len_ff, rsp_len_in;

   logic accept;
   logic res_valid;
   fbr_pkg::kind_type res_kind;
   logic [fbr_pkg::BYTE_W-1:0] res_data;
   logic [fbr_pkg::LEN_W-1:0] res_len;

   logic cfg_write;
   logic at_limit;
   logic [fbr_pkg::PROD_W-1:0] count_ext, count_x7;
   logic [2*fbr_pkg::SYM_W-1:0] combined, shifted;
   logic [fbr_pkg::HELD_W-1:0] held_dec;
   logic [fbr_pkg::SYM_W-1:0] keep_mask;

   // CSR access
   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == fbr_pkg::REG_MAX_SYMBOLS)
                       ? fbr_pkg::DATA_W'(max_symbols_ff) : '0;

   always_comb begin
      max_symbols_in = max_symbols_ff;
      if (cfg_write && (csr_paddr[2] == fbr_pkg::REG_MAX_SYMBOLS)) begin
         max_symbols_in = csr_pwdata[fbr_pkg::CFG_W-1:0];
      end
   end

   // handshake: hold input only while a result waits and is stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   // overflow when the count reached min(max_symbols, counter max)
   assign at_limit = (fbr_pkg::LIM_W'(state_ff.symbol_count) >= fbr_pkg::LIM_W'(max_symbols_ff))
                     || (state_ff.symbol_count == fbr_pkg::COUNT_MAX);

   // frame length = count * 7 / 8
   assign count_ext = fbr_pkg::PROD_W'(state_ff.symbol_count);
   assign count_x7 = (count_ext << 3) - count_ext;

   // repack: append 7 new bits below the held ones
   assign combined = {state_ff.bit_store, req_in_byte[fbr_pkg::SYM_W-1:0]};
   assign held_dec = state_ff.bits_held - 3'd1;
   assign shifted = combined >> held_dec;
   assign keep_mask = (fbr_pkg::SYM_W'(1) << held_dec) - fbr_pkg::SYM_W'(1);

   // decode one line byte
   always_comb begin
      state_in = state_ff;
      res_valid = 1'b0;
      res_kind = fbr_pkg::KIND_DATA;
      res_data = '0;
      res_len = '0;
      if (req_in_byte[fbr_pkg::BYTE_W-1]) begin
         if (req_in_byte == fbr_pkg::MARK_START) begin
            state_in = '0;
            state_in.in_frame = 1'b1;
         end else if (req_in_byte == fbr_pkg::MARK_END) begin
            if (state_ff.in_frame) begin
               state_in = '0;
               res_valid = 1'b1;
               if (state_ff.symbol_count < fbr_pkg::COUNT_BITS'(2)) begin
                  res_kind = fbr_pkg::KIND_INVALID;
               end else begin
                  res_kind = fbr_pkg::KIND_DONE;
                  res_len = count_x7[fbr_pkg::LEN_W+2:3];
               end
            end
         end else begin
            // unknown marker aborts, inside or outside a frame
            state_in = '0;
            res_valid = 1'b1;
            res_kind = fbr_pkg::KIND_INVALID;
         end
      end else if (state_ff.in_frame) begin
         if (at_limit) begin
            state_in = '0;
            res_valid = 1'b1;
            res_kind = fbr_pkg::KIND_OVERFLOW;
         end else begin
            state_in.symbol_count = state_ff.symbol_count + fbr_pkg::COUNT_BITS'(1);
            if (state_ff.bits_held == '0) begin
               state_in.bit_store = req_in_byte[fbr_pkg::SYM_W-1:0];
               state_in.bits_held = 3'd7;
            end else begin
               res_valid = 1'b1;
               res_kind = fbr_pkg::KIND_DATA;
               res_data = shifted[fbr_pkg::BYTE_W-1:0];
               state_in.bits_held = held_dec;
               state_in.bit_store = combined[fbr_pkg::SYM_W-1:0] & keep_mask;
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_data_in = rsp_data_ff;
      rsp_len_in = rsp_len_ff;
      if (accept && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in = res_kind;
         rsp_data_in = res_data;
         rsp_len_in = res_len;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         max_symbols_ff <= fbr_pkg::MAX_SYMBOLS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         max_symbols_ff <= max_symbols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_len_ff <= rsp_len_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_frame_length = rsp_len_ff;

endmodule

FILE: src/fbr_checker.sv
// Port-level checks for the framed base-128 receiver, bound to the top level.
`timescale 1ns / 1ps

module fbr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [fbr_pkg::KIND_W-1:0]  rsp_kind,
   input logic [fbr_pkg::BYTE_W-1:0]  rsp_data_byte,
   input logic [fbr_pkg::LEN_W-1:0]   rsp_frame_length
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_frame_length))
      else $error("stalled result changed");

   // input is held back only by a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // data byte is zero unless the item is a data byte
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != fbr_pkg::KIND_DATA) |-> rsp_data_byte == '0)
      else $error("data byte set on a non-data item");

   // length is zero unless the item is a done
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != fbr_pkg::KIND_DONE) |-> rsp_frame_length == '0)
      else $error("frame length set on a non-done item");

endmodule

bind framed_base128_receiver_unit fbr_checker u_fbr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_frame_length (rsp_frame_length)
);
